// File: hdl/acd_pkg.sv
// Package for the archive chunk deframer: result kinds, error codes,
// the queue entry type and the magic table. No dependencies.
`default_nettype none
package acd_pkg;
    typedef enum logic [2:0] {
        K_DATA = 3'd0, K_NAME = 3'd1, K_DSTART = 3'd2, K_FSTART = 3'd3,
        K_OK = 3'd4, K_ERR = 3'd5, K_DONE = 3'd6
    } t_kind;

    typedef enum logic [1:0] {
        E_NONE = 2'd0, E_MAGIC = 2'd1, E_SUM = 2'd2, E_TRUNC = 2'd3
    } t_err;

    localparam logic [15:0] ID_FILE = 16'd1;
    localparam logic [15:0] ID_DATA = 16'd17;
    localparam logic [31:0] FILE_HDR_MIN = 32'd10;
    localparam logic [16:0] ADLER_MOD = 17'd65521;

    // One result item as it sits in the queue.
    typedef struct packed {
        t_kind       kind;
        logic [7:0]  data;
        logic [31:0] word;
        t_err        err;
        logic        last;
    } t_res;

    // Up to three results caused by one byte, plus a count.
    typedef struct packed {
        logic [1:0] cnt;
        t_res       r0;
        t_res       r1;
        t_res       r2;
    } t_bundle;

    function automatic logic [7:0] magic_byte(input logic [2:0] idx);
        case (idx)
            3'd0: magic_byte = 8'h24;
            3'd1: magic_byte = 8'h70;
            3'd2: magic_byte = 8'h68;
            3'd3: magic_byte = 8'h79;
            3'd4: magic_byte = 8'h7a;
            3'd5: magic_byte = 8'h69;
            3'd6: magic_byte = 8'h70;
            default: magic_byte = 8'h24;
        endcase
    endfunction
endpackage
`default_nettype wire

// File: hdl/acd_front.sv
// Front part: parses the byte stream, keeps the Adler-32 sums and produces
// a bundle of up to three results for each byte. Depends on acd_pkg.
`default_nettype none
module acd_front #(
    parameter int MAX_HEADER_CHUNK = 65536
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_take,
    input  wire logic [7:0]      i_byte,
    input  wire logic            i_end,
    output acd_pkg::t_bundle     o_bundle
);
    import acd_pkg::*;

    typedef enum logic [2:0] {
        PH_MAGIC, PH_HEADER, PH_FILE, PH_DATA, PH_SKIP, PH_HALT, PH_DONE
    } t_phase;

    localparam logic [31:0] MaxHdr = 32'(MAX_HEADER_CHUNK);

    t_phase      r_phase, n_phase;
    logic [31:0] r_idx, n_idx;
    logic [15:0] r_ckind, n_ckind;
    logic [31:0] r_clen, n_clen, r_exp, n_exp, r_raw, n_raw;
    logic [15:0] r_alo, n_alo, r_ahi, n_ahi;
    logic [31:0] r_fsize, n_fsize;
    logic [15:0] r_nlen, n_nlen;
    logic        r_fseen, n_fseen;

    t_res        res [3];
    logic [1:0]  cnt;
    logic [16:0] lo_s, hi_s;
    logic [15:0] lo_m;
    logic [31:0] idx1, sum;
    logic [3:0]  k;

    always_comb begin
        lo_s = {1'b0, r_alo} + {9'd0, i_byte};
        lo_m = (lo_s >= ADLER_MOD) ? 16'(lo_s - ADLER_MOD) : lo_s[15:0];
        hi_s = {1'b0, r_ahi} + {1'b0, lo_m};
    end

    always_comb begin
        n_phase = r_phase; n_idx = r_idx; n_ckind = r_ckind; n_clen = r_clen;
        n_exp = r_exp; n_raw = r_raw; n_alo = r_alo; n_ahi = r_ahi;
        n_fsize = r_fsize; n_nlen = r_nlen; n_fseen = r_fseen;
        cnt = 2'd0;
        for (int j = 0; j < 3; j++) begin
            res[j] = '{kind: K_DATA, data: 8'd0, word: 32'd0, err: E_NONE, last: 1'b0};
        end
        idx1 = r_idx + 32'd1;
        k = r_idx[3:0];
        sum = 32'd0;
        case (r_phase)
            PH_MAGIC: begin
                if (i_byte != magic_byte(r_idx[2:0])) begin
                    res[0] = '{kind: K_ERR, data: 8'd0, word: 32'd0, err: E_MAGIC, last: 1'b0};
                    cnt = 2'd1;
                    n_phase = PH_HALT;
                end else if (r_idx[2:0] == 3'd7) begin
                    n_phase = PH_HEADER; n_idx = 32'd0;
                end else begin
                    n_idx = idx1;
                end
            end
            PH_HEADER: begin
                case (k[3:2])
                    2'd0: if (!k[1]) n_ckind[8*k[0] +: 8] = i_byte;
                    2'd1: n_clen[8*k[1:0] +: 8] = i_byte;
                    2'd2: n_exp[8*k[1:0] +: 8] = i_byte;
                    default: n_raw[8*k[1:0] +: 8] = i_byte;
                endcase
                n_idx = {28'd0, k + 4'd1};
                if (k == 4'd15) begin
                    n_idx = 32'd0; n_alo = 16'd1; n_ahi = 16'd0;
                    if (n_ckind == ID_FILE && n_clen > FILE_HDR_MIN && n_clen < MaxHdr) begin
                        n_phase = PH_FILE; n_fsize = 32'd0; n_nlen = 16'd0;
                    end else if (n_ckind == ID_DATA && r_fseen && r_fsize != 32'd0) begin
                        res[0] = '{kind: K_DSTART, data: 8'd0, word: n_raw, err: E_NONE, last: 1'b0};
                        cnt = 2'd1;
                        n_phase = PH_DATA;
                        if (n_clen == 32'd0) begin
                            // Empty payload: the sum is just the seed.
                            if (n_exp == 32'd1) begin
                                res[1] = '{kind: K_OK, data: 8'd0, word: 32'd1, err: E_NONE, last: 1'b0};
                                n_phase = PH_HEADER;
                            end else begin
                                res[1] = '{kind: K_ERR, data: 8'd0, word: 32'd1, err: E_SUM, last: 1'b0};
                                n_phase = PH_HALT;
                            end
                            cnt = 2'd2;
                        end
                    end else begin
                        n_phase = (n_clen == 32'd0) ? PH_HEADER : PH_SKIP;
                    end
                end
            end
            PH_FILE, PH_DATA: begin
                n_alo = lo_m;
                n_ahi = (hi_s >= ADLER_MOD) ? 16'(hi_s - ADLER_MOD) : hi_s[15:0];
                n_idx = idx1;
                if (r_phase == PH_DATA) begin
                    res[0] = '{kind: K_DATA, data: i_byte, word: 32'd0, err: E_NONE, last: 1'b0};
                    cnt = 2'd1;
                end else if (r_idx < 32'd4) begin
                    n_fsize[8*r_idx[1:0] +: 8] = i_byte;
                    if (r_idx[1:0] == 2'd3) begin
                        res[0] = '{kind: K_FSTART, data: 8'd0, word: n_fsize, err: E_NONE, last: 1'b0};
                        cnt = 2'd1;
                    end
                end else if (r_idx == 32'd8) begin
                    n_nlen = {8'd0, i_byte};
                end else if (r_idx == 32'd9) begin
                    n_nlen[15:8] = i_byte;
                end else if (r_idx >= 32'd10 && (r_idx - 32'd10) < {16'd0, r_nlen}) begin
                    res[0] = '{kind: K_NAME, data: i_byte, word: 32'd0, err: E_NONE, last: 1'b0};
                    cnt = 2'd1;
                end
                if (idx1 >= r_clen) begin
                    sum = {n_ahi, n_alo};
                    n_idx = 32'd0;
                    if (sum == r_exp) begin
                        res[cnt] = '{kind: K_OK, data: 8'd0, word: sum, err: E_NONE, last: 1'b0};
                        if (r_phase == PH_FILE) n_fseen = 1'b1;
                        n_phase = PH_HEADER;
                    end else begin
                        res[cnt] = '{kind: K_ERR, data: 8'd0, word: sum, err: E_SUM, last: 1'b0};
                        n_phase = PH_HALT;
                    end
                    cnt = cnt + 2'd1;
                end
            end
            PH_SKIP: begin
                n_idx = idx1;
                if (idx1 >= r_clen) begin
                    n_phase = PH_HEADER; n_idx = 32'd0;
                end
            end
            default: ;
        endcase
        if (r_phase != PH_HALT && r_phase != PH_DONE && i_end && n_phase != PH_HALT) begin
            if (n_phase == PH_MAGIC) begin
                res[cnt] = '{kind: K_ERR, data: 8'd0, word: 32'd0, err: E_MAGIC, last: 1'b0};
                n_phase = PH_HALT;
            end else if (n_phase == PH_HEADER && n_idx == 32'd0) begin
                res[cnt] = '{kind: K_DONE, data: 8'd0, word: 32'd0, err: E_NONE, last: 1'b0};
                n_phase = PH_DONE;
            end else begin
                res[cnt] = '{kind: K_ERR, data: 8'd0, word: 32'd0, err: E_TRUNC, last: 1'b0};
                n_phase = PH_HALT;
            end
            cnt = cnt + 2'd1;
        end
        if (cnt != 2'd0) res[cnt - 2'd1].last = 1'b1;
    end

    assign o_bundle = '{cnt: i_take ? cnt : 2'd0, r0: res[0], r1: res[1], r2: res[2]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_MAGIC; r_idx <= '0; r_ckind <= '0; r_clen <= '0;
            r_exp <= '0; r_raw <= '0; r_alo <= 16'd1; r_ahi <= '0;
            r_fsize <= '0; r_nlen <= '0; r_fseen <= 1'b0;
        end else if (i_take) begin
            r_phase <= n_phase; r_idx <= n_idx; r_ckind <= n_ckind; r_clen <= n_clen;
            r_exp <= n_exp; r_raw <= n_raw; r_alo <= n_alo; r_ahi <= n_ahi;
            r_fsize <= n_fsize; r_nlen <= n_nlen; r_fseen <= n_fseen;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_HALT) |=> (r_phase == PH_HALT)) else $error("left halt");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DONE || r_phase == PH_HALT) |-> (o_bundle.cnt == 2'd0))
        else $error("result after stop");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_HEADER) |-> (r_idx < 32'd16)) else $error("header index");
endmodule
`default_nettype wire

// File: hdl/acd_queue.sv
// Result queue between parser and output: takes up to three items a cycle,
// delivers one a cycle while popped, read at r_rp. Depends on acd_pkg.
`default_nettype none
module acd_queue #(
    parameter int DEPTH = 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  acd_pkg::t_bundle      i_bundle,
    output logic                  o_room,
    output logic                  o_valid,
    output acd_pkg::t_res         o_res,
    input  wire logic             i_pop
);
    import acd_pkg::*;

    localparam int AW = $clog2(DEPTH);

    t_res            r_mem [DEPTH];
    logic [AW-1:0]   r_wp, r_rp;
    logic [AW:0]     r_cnt, n_cnt;
    logic            pop;

    assign pop = i_pop && (r_cnt != '0);
    assign o_valid = (r_cnt != '0);
    assign o_res = r_mem[r_rp];
    // Room for a worst-case bundle of three, not counting this cycle's pop.
    assign o_room = (r_cnt <= (AW+1)'(DEPTH - 3));
    assign n_cnt = r_cnt + {{(AW-1){1'b0}}, i_bundle.cnt} - {{AW{1'b0}}, pop};

    always_ff @(posedge i_clk) begin
        if (i_bundle.cnt > 2'd0) r_mem[r_wp] <= i_bundle.r0;
        if (i_bundle.cnt > 2'd1) r_mem[AW'(r_wp + AW'(1))] <= i_bundle.r1;
        if (i_bundle.cnt > 2'd2) r_mem[AW'(r_wp + AW'(2))] <= i_bundle.r2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            r_wp <= r_wp + AW'(i_bundle.cnt);
            if (pop) r_rp <= r_rp + AW'(1);
            r_cnt <= n_cnt;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (AW+1)'(DEPTH)) else $error("queue overflow");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_bundle.cnt != 2'd0) |-> o_room) else $error("bundle without room");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0 && i_bundle.cnt == 2'd0) |=> !o_valid) else $error("phantom");
endmodule
`default_nettype wire

// File: hdl/archive_chunk_deframer_unit.sv
// Top level of the archive chunk deframer: byte parser feeding a small
// result queue. Depends on acd_pkg, acd_front and acd_queue.
//
//  channel | dir | tdata                | tuser
//  s_axis  | in  | in_byte[7:0]         | -         (tlast = in_end)
//  m_axis  | out | byte,word,error      | kind[2:0] (tlast = out_last)
//
// One input byte is taken per cycle; its zero to three results enter the queue
// together and leave one per cycle while the receiver is ready, so sustained
// rate is one byte a cycle except where a byte yields more than one result, set
// by the single queue read port, or the receiver stalls. Reset, synchronous and
// active low, empties the queue. tready drops only while it lacks room for three results.
`default_nettype none
module archive_chunk_deframer_unit #(
    parameter int MAX_HEADER_CHUNK = 65536,
    parameter int QUEUE_DEPTH = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [47:0]      m_axis_tdata,   // [7:0] out_byte, [39:8] out_word, [41:40] out_error
    output logic [2:0]       m_axis_tuser,   // [2:0] out_kind
    output logic             m_axis_tlast
);
    import acd_pkg::*;

    t_bundle bundle;
    t_res    head;
    logic    room, take;

    assign s_axis_tready = room;
    assign take = s_axis_tvalid && room;

    acd_front #(.MAX_HEADER_CHUNK(MAX_HEADER_CHUNK)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_take(take),
        .i_byte(s_axis_tdata), .i_end(s_axis_tlast), .o_bundle(bundle)
    );

    acd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_bundle(bundle), .o_room(room),
        .o_valid(m_axis_tvalid), .o_res(head), .i_pop(m_axis_tready)
    );

    assign m_axis_tdata = {6'd0, head.err, head.word, head.data};
    assign m_axis_tuser = head.kind;
    assign m_axis_tlast = head.last;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid) else $error("valid dropped");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !take |-> (bundle.cnt == 2'd0)) else $error("results without byte");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser != K_ERR) |-> (m_axis_tdata[41:40] == E_NONE))
        else $error("error code on non-error");
endmodule
`default_nettype wire

// File: dv/tb_top.sv
// Self-checking testbench for archive_chunk_deframer_unit: drives archive byte
// streams, predicts every result in a behavioral model and compares fields.
// Depends on acd_pkg and the deframer top level.
`default_nettype none
module tb_top;
    import acd_pkg::*;

    localparam int HDR_MAX = 65536;
    localparam int LIMIT_CYCLES = 400000;

    typedef enum logic [2:0] {
        P_MAGIC, P_HEADER, P_FILE, P_DATA, P_SKIP, P_HALT, P_DONE
    } t_phase;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  data;
        logic [31:0] word;
        t_err        err;
        logic        last;
    } t_expect;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'd0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;   // [7:0] out_byte, [39:8] out_word, [41:40] out_error
    logic [2:0]  m_axis_tuser;   // [2:0] out_kind
    logic        m_axis_tlast;

    archive_chunk_deframer_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast)
    );

    always #5 i_clk = ~i_clk;

    // Predictor state, mirrors the deframer's registers.
    t_phase      ph;
    logic [31:0] idx, clen, csum, rlen, fsize;
    logic [15:0] ckind, nlen, alo, ahi;
    logic        fseen;
    t_expect     pending[$];
    t_expect     step_out[$];

    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int          errors = 0;
    int          cycles = 0;

    function automatic logic [7:0] magic_char(input int k);
        logic [7:0] tbl[8];
        tbl = '{8'h24, 8'h70, 8'h68, 8'h79, 8'h7a, 8'h69, 8'h70, 8'h24};
        return tbl[k & 7];
    endfunction

    function automatic void push(input t_kind k, input logic [7:0] d,
                                 input logic [31:0] w, input t_err e);
        t_expect x;
        x.kind = k; x.data = d; x.word = w; x.err = e; x.last = 1'b0;
        step_out.push_back(x);
    endfunction

    function automatic void model_reset();
        ph = P_MAGIC; idx = 0; ckind = 0; clen = 0; csum = 0; rlen = 0;
        alo = 1; ahi = 0; fsize = 0; nlen = 0; fseen = 0;
    endfunction

    function automatic void adler_add(input logic [7:0] b);
        logic [16:0] t;
        t = alo + b;
        if (t >= 17'd65521) t = t - 17'd65521;
        alo = t[15:0];
        t = ahi + alo;
        if (t >= 17'd65521) t = t - 17'd65521;
        ahi = t[15:0];
    endfunction

    function automatic void close_payload();
        logic [31:0] s;
        s = {ahi, alo};
        if (s == csum) begin
            push(K_OK, 8'd0, s, E_NONE);
            if (ph == P_FILE) fseen = 1'b1;
            ph = P_HEADER;
        end else begin
            push(K_ERR, 8'd0, s, E_SUM);
            ph = P_HALT;
        end
        idx = 0;
    endfunction

    // Advances the model by one archive byte and queues its results.
    function automatic void predict_byte(input logic [7:0] b, input logic fin);
        int k;
        step_out.delete();
        if (ph == P_HALT || ph == P_DONE) return;
        case (ph)
            P_MAGIC: begin
                if (b != magic_char(idx)) begin
                    push(K_ERR, 8'd0, 32'd0, E_MAGIC);
                    ph = P_HALT;
                end else begin
                    idx++;
                    if (idx >= 8) begin
                        ph = P_HEADER; idx = 0;
                    end
                end
            end
            P_HEADER: begin
                k = idx & 15;
                if (k < 2) begin
                    if (k == 0) ckind = 0;
                    ckind[8*k +: 8] = b;
                end else if (k >= 4 && k < 8) begin
                    if (k == 4) clen = 0;
                    clen[8*(k-4) +: 8] = b;
                end else if (k >= 8 && k < 12) begin
                    if (k == 8) csum = 0;
                    csum[8*(k-8) +: 8] = b;
                end else if (k >= 12) begin
                    if (k == 12) rlen = 0;
                    rlen[8*(k-12) +: 8] = b;
                end
                idx = k + 1;
                if (idx == 16) begin
                    idx = 0; alo = 1; ahi = 0;
                    if (ckind == ID_FILE && clen > 10 && clen < HDR_MAX) begin
                        ph = P_FILE; fsize = 0; nlen = 0;
                    end else if (ckind == ID_DATA && fseen && fsize != 0) begin
                        push(K_DSTART, 8'd0, rlen, E_NONE);
                        ph = P_DATA;
                        if (clen == 0) close_payload();
                    end else begin
                        ph = (clen == 0) ? P_HEADER : P_SKIP;
                    end
                end
            end
            P_FILE: begin
                k = idx;
                adler_add(b);
                if (k < 4) begin
                    fsize[8*k +: 8] = b;
                    if (k == 3) push(K_FSTART, 8'd0, fsize, E_NONE);
                end else if (k == 8) begin
                    nlen = {8'd0, b};
                end else if (k == 9) begin
                    nlen[15:8] = b;
                end else if (k >= 10 && (k - 10) < nlen) begin
                    push(K_NAME, b, 32'd0, E_NONE);
                end
                idx = k + 1;
                if (idx >= clen) close_payload();
            end
            P_DATA: begin
                adler_add(b);
                push(K_DATA, b, 32'd0, E_NONE);
                idx++;
                if (idx >= clen) close_payload();
            end
            default: begin
                idx++;
                if (idx >= clen) begin
                    ph = P_HEADER; idx = 0;
                end
            end
        endcase
        if (fin && ph != P_HALT) begin
            if (ph == P_MAGIC) begin
                push(K_ERR, 8'd0, 32'd0, E_MAGIC); ph = P_HALT;
            end else if (ph == P_HEADER && idx == 0) begin
                push(K_DONE, 8'd0, 32'd0, E_NONE); ph = P_DONE;
            end else begin
                push(K_ERR, 8'd0, 32'd0, E_TRUNC); ph = P_HALT;
            end
        end
        if (step_out.size() > 0) step_out[step_out.size()-1].last = 1'b1;
        foreach (step_out[i]) pending.push_back(step_out[i]);
    endfunction

    // Sends one archive byte, with random idle cycles before it.
    task automatic send_byte(input logic [7:0] b, input logic fin);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= fin;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_byte(b, fin);
    endtask

    task automatic go_idle();
        s_axis_tvalid <= 1'b0;
        s_axis_tlast  <= 1'b0;
    endtask

    // The receiver raises and lowers tready at random each cycle.
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Checks each accepted result against the oldest expectation.
    always @(posedge i_clk) begin
        t_expect x;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending.size() == 0) begin
                $display("%0t: unexpected result kind=%0d byte=%h word=%h err=%0d",
                         $time, m_axis_tuser, m_axis_tdata[7:0],
                         m_axis_tdata[39:8], m_axis_tdata[41:40]);
                errors++;
            end else begin
                x = pending.pop_front();
                if (m_axis_tuser != x.kind || m_axis_tdata[7:0] != x.data ||
                    m_axis_tdata[39:8] != x.word || m_axis_tdata[41:40] != x.err ||
                    m_axis_tlast != x.last || m_axis_tdata[47:42] != 6'd0) begin
                    $display("%0t: expected kind=%0d byte=%h word=%h err=%0d last=%b",
                             $time, x.kind, x.data, x.word, x.err, x.last);
                    $display("%0t: actual   kind=%0d byte=%h word=%h err=%0d last=%b",
                             $time, m_axis_tuser, m_axis_tdata[7:0],
                             m_axis_tdata[39:8], m_axis_tdata[41:40], m_axis_tlast);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Only the first test case starts a fresh archive; the deframer halts at
    // the end of one, so only the first archive per reset is meaningful.
    // One reset exists, so later test cases continue that archive, and any byte
    // after its end is fed into a halted or done block and must produce nothing.
    // To still reach deep behavior, one long archive carries most of the stimulus.

    task automatic wait_drain();
        go_idle();
        while (pending.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic send_magic();
        for (int i = 0; i < 8; i++) send_byte(magic_char(i), 1'b0);
    endtask

    function automatic logic [31:0] adler_of(input logic [7:0] d[$]);
        logic [31:0] lo, hi;
        lo = 1; hi = 0;
        foreach (d[i]) begin
            lo = (lo + d[i]) % 65521;
            hi = (hi + lo) % 65521;
        end
        return {hi[15:0], lo[15:0]};
    endfunction

    // Sends a chunk: header then payload. A bad checksum is used on request.
    task automatic send_chunk(input logic [15:0] id, input logic [7:0] pay[$],
                              input logic [31:0] raw, input bit good_sum,
                              input bit fin_last);
        logic [7:0]  h[16];
        logic [31:0] sz, sm;
        sz = pay.size();
        sm = adler_of(pay);
        if (!good_sum) sm = sm ^ (32'd1 << $urandom_range(31));
        h[0] = id[7:0]; h[1] = id[15:8];
        h[2] = 8'($urandom); h[3] = 8'($urandom);
        for (int i = 0; i < 4; i++) begin
            h[4+i]  = sz[8*i +: 8];
            h[8+i]  = sm[8*i +: 8];
            h[12+i] = raw[8*i +: 8];
        end
        for (int i = 0; i < 16; i++)
            send_byte(h[i], fin_last && pay.size() == 0 && i == 15);
        foreach (pay[i]) send_byte(pay[i], fin_last && i == pay.size() - 1);
    endtask

    function automatic void file_payload(output logic [7:0] p[$],
                                         input logic [31:0] fs,
                                         input int nl, input int total);
        p.delete();
        for (int i = 0; i < total; i++) p.push_back(8'($urandom));
        for (int i = 0; i < 4; i++) p[i] = fs[8*i +: 8];
        p[8] = nl[7:0]; p[9] = nl[15:8];
    endfunction

    function automatic void rand_payload(output logic [7:0] p[$], input int n);
        p.delete();
        for (int i = 0; i < n; i++) p.push_back(8'($urandom));
    endfunction

    // The directed part: file header, empty data chunk, extreme bytes, a
    // skipped chunk and a name longer than the chunk.
    task automatic test_directed();
        logic [7:0] p[$];
        send_magic();
        file_payload(p, 32'hFFFF_FFFF, 300, 13);   // name capped by chunk length
        send_chunk(ID_FILE, p, 32'd0, 1'b1, 1'b0);
        p.delete();
        send_chunk(ID_DATA, p, 32'h8000_0001, 1'b1, 1'b0);   // empty data chunk
        p = '{8'h00, 8'hFF, 8'h80, 8'h7F};
        send_chunk(ID_DATA, p, 32'd4, 1'b1, 1'b0);
        rand_payload(p, 3);
        send_chunk(16'hFFFF, p, 32'd0, 1'b0, 1'b0);          // skipped, unchecked
        p.delete();
        send_chunk(16'h0005, p, 32'd0, 1'b1, 1'b0);          // empty skipped chunk
        wait_drain();   // sender holds off until all results have come
    endtask

    // Random chunks, mostly well formed, inside the same archive.
    task automatic test_random(input int n_chunks);
        logic [7:0] p[$];
        int sel;
        for (int c = 0; c < n_chunks; c++) begin
            sel = $urandom_range(9);
            if (sel < 2) begin
                file_payload(p, (sel == 0) ? 32'd0 : $urandom, $urandom_range(6),
                             $urandom_range(11, 16));
                send_chunk(ID_FILE, p, $urandom, 1'b1, 1'b0);
            end else if (sel < 8) begin
                rand_payload(p, $urandom_range(0, 8));
                send_chunk(ID_DATA, p, $urandom, 1'b1, 1'b0);
            end else begin
                rand_payload(p, $urandom_range(0, 4));
                send_chunk((sel == 8) ? ID_FILE : 16'(ID_DATA + 1), p, $urandom,
                           1'b0, 1'b0);
            end
        end
    endtask

    // Ends the archive cleanly after a last data chunk, then shows that
    // further bytes after done produce nothing.
    task automatic test_finish();
        logic [7:0] p[$];
        rand_payload(p, 5);
        send_chunk(ID_DATA, p, 32'd5, 1'b1, 1'b1);
        for (int i = 0; i < 6; i++) send_byte(8'($urandom), 1'($urandom_range(1)));
        wait_drain();
    endtask

    initial begin
        model_reset();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        send_idle_pct = 0;  recv_stall_pct = 0;  test_random(4);
        send_idle_pct = 59; recv_stall_pct = 0;  test_random(4);
        send_idle_pct = 0;  recv_stall_pct = 59; test_random(4);
        send_idle_pct = 29; recv_stall_pct = 29; test_random(4);
        send_idle_pct = 0;  recv_stall_pct = 0;
        test_finish();
        if (errors == 0 && pending.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
`default_nettype wire
